// ----- rtl/core/owbm_pkg.sv -----
// Shared types, register indexes and constants for the 1-Wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

   // Width of every timing register, and of the slot tick counter.
   localparam int unsigned TICK_W   = 12;
   localparam int unsigned CSR_IDX_W = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESENCE_REC  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_SLOT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_READ_LOW      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_READ_SLOT     = 3'd6;

   // Timing register values after reset, in 1 us ticks.
   localparam logic [TICK_W-1:0] RST_RESET_LOW     = 12'd480;
   localparam logic [TICK_W-1:0] RST_PRESENCE_WAIT = 12'd80;
   localparam logic [TICK_W-1:0] RST_PRESENCE_REC  = 12'd400;
   localparam logic [TICK_W-1:0] RST_WRITE_ONE_LOW = 12'd1;
   localparam logic [TICK_W-1:0] RST_WRITE_SLOT    = 12'd60;
   localparam logic [TICK_W-1:0] RST_READ_LOW      = 12'd2;
   localparam logic [TICK_W-1:0] RST_READ_SLOT     = 12'd60;

   // Item kinds on the request channel.
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // Bus sequencer phases.
   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_RST_LOW = 8'b0000_0010,
      PH_RST_WT  = 8'b0000_0100,
      PH_RST_REC = 8'b0000_1000,
      PH_WR_LOW  = 8'b0001_0000,
      PH_WR_REL  = 8'b0010_0000,
      PH_RD_LOW  = 8'b0100_0000,
      PH_RD_WT   = 8'b1000_0000
   } phase_type;

   // Timing registers as seen by the sequencer.
   typedef struct packed {
      logic [TICK_W-1:0] reset_low_ticks;
      logic [TICK_W-1:0] presence_wait_ticks;
      logic [TICK_W-1:0] presence_recovery_ticks;
      logic [TICK_W-1:0] write_one_low_ticks;
      logic [TICK_W-1:0] write_slot_ticks;
      logic [TICK_W-1:0] read_low_ticks;
      logic [TICK_W-1:0] read_slot_ticks;
   } cfg_type;

   // One request item.
   typedef struct packed {
      logic [1:0] action;
      logic       line_level;
      logic [7:0] data_byte;
   } item_type;

   // One result item.
   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
      logic       rejected;
   } result_type;

   // A zero-length interval still lasts one tick.
   function automatic logic [TICK_W-1:0] span_f(input logic [TICK_W-1:0] v);
      span_f = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
   endfunction

endpackage

// ----- rtl/core/one_wire_bus_master_top.sv -----
// Top level of the 1-Wire bus master: stream ports, input and result registers.
`timescale 1ns / 1ps

// 1-Wire bus master for reset/presence, write byte and read byte. Feed it
// one request per 1 us tick (kind 0, with the sampled line level) plus
// command requests (1 reset, 2 write byte, 3 read byte); each request gives
// exactly one response whose drive_low says whether to pull the line low
// during the next tick. A command that arrives while an operation runs is
// answered with rejected set and otherwise ignored. The block accepts one
// request every clock cycle while the response side does not stall: a
// request passes an input register, then one pass of the slot-timer and
// sequencer update writes its response into the result register, which
// offers it until the response side takes it. Timing registers may only be
// written while no request or response is held in the block; a write while
// an operation runs applies at once to the phase that is running.
module one_wire_bus_master_top (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // line_level, data_byte, zero fill
   input  logic [1:0]                       req_tuser,  // action
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,  // drive_low, busy_res, done_res,
                                                        // presence, read_data, rejected,
                                                        // zero fill
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [owbm_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [owbm_pkg::TICK_W-1:0]      csr_wdata
);
   import owbm_pkg::*;

   cfg_type    cfg;
   logic       in_vld_ff, in_vld_in;
   item_type   in_item_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_res_ff;
   result_type eng_res;
   logic       adv;

   // The input register moves on when the result register is free.
   assign adv        = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;

   assign in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
   assign out_vld_in = adv ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.action     <= req_tuser;
         in_item_ff.line_level <= req_tdata[0];
         in_item_ff.data_byte  <= req_tdata[8:1];
      end
      if (adv) begin
         out_res_ff <= eng_res;
      end
   end

   owbm_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owbm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .adv    (adv),
      .item   (in_item_ff),
      .result (eng_res)
   );

   // Pack the response fields from the lowest bit up.
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000,
                        out_res_ff.rejected,
                        out_res_ff.read_data,
                        out_res_ff.presence,
                        out_res_ff.done_res,
                        out_res_ff.busy_res,
                        out_res_ff.drive_low};

endmodule

// ----- rtl/core/owbm_cfg_regs.sv -----
// Timing register file written through the configuration port.
`timescale 1ns / 1ps

module owbm_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [owbm_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [owbm_pkg::TICK_W-1:0]      csr_wdata,
   output owbm_pkg::cfg_type                cfg
);
   import owbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_RESET_LOW:     cfg_in.reset_low_ticks         = csr_wdata;
            REG_PRESENCE_WAIT: cfg_in.presence_wait_ticks     = csr_wdata;
            REG_PRESENCE_REC:  cfg_in.presence_recovery_ticks = csr_wdata;
            REG_WRITE_ONE_LOW: cfg_in.write_one_low_ticks     = csr_wdata;
            REG_WRITE_SLOT:    cfg_in.write_slot_ticks        = csr_wdata;
            REG_READ_LOW:      cfg_in.read_low_ticks          = csr_wdata;
            REG_READ_SLOT:     cfg_in.read_slot_ticks         = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers load their standard 1-Wire timings on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks         <= RST_RESET_LOW;
         cfg_ff.presence_wait_ticks     <= RST_PRESENCE_WAIT;
         cfg_ff.presence_recovery_ticks <= RST_PRESENCE_REC;
         cfg_ff.write_one_low_ticks     <= RST_WRITE_ONE_LOW;
         cfg_ff.write_slot_ticks        <= RST_WRITE_SLOT;
         cfg_ff.read_low_ticks          <= RST_READ_LOW;
         cfg_ff.read_slot_ticks         <= RST_READ_SLOT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/owbm_engine.sv -----
// Bus sequencer: slot timer, bit shifter and the result of each item.
`timescale 1ns / 1ps

module owbm_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  owbm_pkg::cfg_type      cfg,
   input  logic                   adv,
   input  owbm_pkg::item_type     item,
   output owbm_pkg::result_type   result
);
   import owbm_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] cnt_ff, cnt_in;
   logic [2:0]        bit_ff, bit_in;
   logic [7:0]        shift_ff, shift_in;
   logic              pres_ff, pres_in;
   logic              drive_ff, drive_in;
   logic [7:0]        rdb_ff, rdb_in;

   logic [TICK_W-1:0] cnt_inc;
   logic [TICK_W-1:0] phase_len;
   logic              first_tick;
   logic              expire;
   logic [7:0]        shift_smp;
   logic              done;
   logic              rej;

   // Length of the running phase; write phases depend on the current bit.
   always_comb begin
      case (phase_ff)
         PH_RST_LOW: phase_len = span_f(cfg.reset_low_ticks);
         PH_RST_WT:  phase_len = span_f(cfg.presence_wait_ticks);
         PH_RST_REC: phase_len = span_f(cfg.presence_recovery_ticks);
         PH_WR_LOW:  phase_len = shift_ff[0] ? span_f(cfg.write_one_low_ticks)
                                             : span_f(cfg.write_slot_ticks);
         PH_WR_REL:  phase_len = shift_ff[0] ? span_f(cfg.write_slot_ticks)
                                             : {{(TICK_W-1){1'b0}}, 1'b1};
         PH_RD_LOW:  phase_len = span_f(cfg.read_low_ticks);
         PH_RD_WT:   phase_len = span_f(cfg.read_slot_ticks);
         default:    phase_len = {{(TICK_W-1){1'b0}}, 1'b1};
      endcase
   end

   assign cnt_inc    = cnt_ff + {{(TICK_W-1){1'b0}}, 1'b1};
   assign first_tick = (cnt_inc == {{(TICK_W-1){1'b0}}, 1'b1});
   assign expire     = (cnt_inc >= phase_len);
   // The read bit is sampled on the first released tick of a read slot.
   assign shift_smp  = (first_tick && phase_ff == PH_RD_WT) ?
                       {item.line_level, shift_ff[7:1]} : shift_ff;

   // Next state for the item in the input register.
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      drive_in = drive_ff;
      rdb_in   = rdb_ff;
      done     = 1'b0;
      rej      = 1'b0;
      if (item.action == ACT_TICK) begin
         if (phase_ff != PH_IDLE) begin
            cnt_in   = cnt_inc;
            shift_in = shift_smp;
            if (first_tick && phase_ff == PH_RST_REC) begin
               pres_in = ~item.line_level;
            end
            if (expire) begin
               cnt_in   = '0;
               drive_in = 1'b0;
               case (phase_ff)
                  PH_RST_LOW: phase_in = PH_RST_WT;
                  PH_RST_WT:  phase_in = PH_RST_REC;
                  PH_WR_LOW:  phase_in = PH_WR_REL;
                  PH_RD_LOW:  phase_in = PH_RD_WT;
                  PH_WR_REL: begin
                     if (bit_ff == 3'd7) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        shift_in = {1'b0, shift_ff[7:1]};
                        phase_in = PH_WR_LOW;
                        drive_in = 1'b1;
                     end
                  end
                  PH_RD_WT: begin
                     if (bit_ff == 3'd7) begin
                        rdb_in   = shift_smp;
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = PH_RD_LOW;
                        drive_in = 1'b1;
                     end
                  end
                  PH_RST_REC: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         rej = 1'b1;
      end else begin
         // Start a command; every operation opens with the line pulled low.
         bit_in   = 3'd0;
         cnt_in   = '0;
         drive_in = 1'b1;
         case (item.action)
            ACT_RESET: begin
               pres_in  = 1'b0;
               phase_in = PH_RST_LOW;
            end
            ACT_WRITE: begin
               shift_in = item.data_byte;
               phase_in = PH_WR_LOW;
            end
            default: begin
               shift_in = 8'd0;
               phase_in = PH_RD_LOW;
            end
         endcase
      end
   end

   // Result of the item, taken from the state it leaves behind.
   always_comb begin
      result.drive_low = drive_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.presence  = pres_in;
      result.read_data = rdb_in;
      result.rejected  = rej;
   end

   // State advances only when the item moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         pres_ff  <= 1'b0;
         drive_ff <= 1'b0;
         rdb_ff   <= 8'd0;
      end else if (adv) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         drive_ff <= drive_in;
         rdb_ff   <= rdb_in;
      end
   end

   // A command that arrives while busy leaves the sequencer untouched.
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (adv && item.action != ACT_TICK && phase_ff != PH_IDLE)
      |=> (phase_ff == $past(phase_ff) && cnt_ff == $past(cnt_ff)))
      else $error("busy command changed the sequencer state");

   // A command accepted while idle starts driving the line at once.
   a_start_drives: assert property (@(posedge clock) disable iff (reset)
      (item.action != ACT_TICK && phase_ff == PH_IDLE)
      |-> (result.drive_low && result.busy_res && !result.rejected))
      else $error("idle command did not start an operation");

   // Completion ends the operation and releases the line.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      result.done_res |-> (!result.busy_res && !result.drive_low))
      else $error("done reported while still busy");

   // The line is only ever pulled low inside an operation.
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      drive_ff |-> (phase_ff != PH_IDLE))
      else $error("line driven low while idle");

endmodule

// ----- tb/one_wire_bus_master_checker.sv -----
// Response checker for the 1-Wire bus master: predicts every response and compares it.
`timescale 1ns / 1ps

module one_wire_bus_master_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // line_level, data_byte, zero fill
   input  logic [1:0]                       req_tuser,  // action
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [15:0]                      rsp_tdata,  // drive_low, busy_res, done_res,
                                                        // presence, read_data, rejected,
                                                        // zero fill
   input  logic                             csr_we,
   input  logic [owbm_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [owbm_pkg::TICK_W-1:0]      csr_wdata,
   // Mismatches plus predictions still waiting; meaningful once traffic has stopped.
   output int unsigned                      fault_count
);
   import owbm_pkg::*;

   // Predicted timing registers and sequencer state.
   cfg_type             timing;
   phase_type           phase;
   logic [TICK_W-1:0]   slot_ticks;
   logic [2:0]          bit_num;
   logic [7:0]          shifter;
   logic                presence_seen;
   logic                line_pulled;
   logic [7:0]          last_read;

   // Predicted responses in transfer order, oldest first.
   result_type          predicted_responses [$];
   int unsigned         waiting;
   int unsigned         mismatches;

   assign fault_count = mismatches + waiting;

   // An interval programmed as zero still lasts one tick.
   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   // Length of the running phase; write phases depend on the bit being sent.
   function automatic logic [TICK_W-1:0] phase_ticks();
      case (phase)
         PH_RST_LOW: return at_least_one(timing.reset_low_ticks);
         PH_RST_WT:  return at_least_one(timing.presence_wait_ticks);
         PH_RST_REC: return at_least_one(timing.presence_recovery_ticks);
         PH_WR_LOW:  return shifter[0] ? at_least_one(timing.write_one_low_ticks)
                                       : at_least_one(timing.write_slot_ticks);
         PH_WR_REL:  return shifter[0] ? at_least_one(timing.write_slot_ticks) : TICK_W'(1);
         PH_RD_LOW:  return at_least_one(timing.read_low_ticks);
         PH_RD_WT:   return at_least_one(timing.read_slot_ticks);
         default:    return TICK_W'(1);
      endcase
   endfunction

   task automatic go_to(input phase_type next_phase, input logic pull);
      phase = next_phase;
      slot_ticks = '0;
      line_pulled = pull;
   endtask

   // One microsecond step of a running operation.
   task automatic slot_tick(input logic level, output logic finished);
      finished = 1'b0;
      slot_ticks = slot_ticks + 1'b1;
      // The first tick of the presence recovery phase or of a read slot's release samples the line.
      if (slot_ticks == TICK_W'(1)) begin
         if (phase == PH_RST_REC) presence_seen = ~level;
         if (phase == PH_RD_WT) shifter = {level, shifter[7:1]};
      end
      if (slot_ticks >= phase_ticks()) begin
         case (phase)
            PH_RST_LOW: go_to(PH_RST_WT, 1'b0);
            PH_RST_WT:  go_to(PH_RST_REC, 1'b0);
            PH_WR_LOW:  go_to(PH_WR_REL, 1'b0);
            PH_RD_LOW:  go_to(PH_RD_WT, 1'b0);
            PH_WR_REL: begin
               if (bit_num == 3'd7) begin
                  go_to(PH_IDLE, 1'b0);
                  finished = 1'b1;
               end else begin
                  bit_num = bit_num + 1'b1;
                  shifter = shifter >> 1;
                  go_to(PH_WR_LOW, 1'b1);
               end
            end
            PH_RD_WT: begin
               if (bit_num == 3'd7) begin
                  last_read = shifter;
                  go_to(PH_IDLE, 1'b0);
                  finished = 1'b1;
               end else begin
                  bit_num = bit_num + 1'b1;
                  go_to(PH_RD_LOW, 1'b1);
               end
            end
            PH_RST_REC: begin
               go_to(PH_IDLE, 1'b0);
               finished = 1'b1;
            end
            default: go_to(PH_IDLE, 1'b0);
         endcase
      end
   endtask

   // Applies one request to the predicted state and forms its response.
   task automatic predict_response(input logic [1:0] kind, input logic level,
                                   input logic [7:0] data_val, output result_type r);
      logic finished;
      logic refused;
      finished = 1'b0;
      refused = 1'b0;
      if (kind == ACT_TICK) begin
         if (phase != PH_IDLE) slot_tick(level, finished);
      end else if (phase != PH_IDLE) begin
         refused = 1'b1;
      end else begin
         bit_num = '0;
         case (kind)
            ACT_RESET: begin
               presence_seen = 1'b0;
               go_to(PH_RST_LOW, 1'b1);
            end
            ACT_WRITE: begin
               shifter = data_val;
               go_to(PH_WR_LOW, 1'b1);
            end
            default: begin
               shifter = '0;
               go_to(PH_RD_LOW, 1'b1);
            end
         endcase
      end
      r.drive_low = line_pulled;
      r.busy_res  = (phase != PH_IDLE);
      r.done_res  = finished;
      r.presence  = presence_seen;
      r.read_data = last_read;
      r.rejected  = refused;
   endtask

   task automatic check_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
      end
   endtask

   // Track request transfers, response transfers and register writes.
   always @(posedge clock) begin
      result_type predicted;
      result_type oldest;
      if (reset) begin
         timing = '{reset_low_ticks:         RST_RESET_LOW,
                    presence_wait_ticks:     RST_PRESENCE_WAIT,
                    presence_recovery_ticks: RST_PRESENCE_REC,
                    write_one_low_ticks:     RST_WRITE_ONE_LOW,
                    write_slot_ticks:        RST_WRITE_SLOT,
                    read_low_ticks:          RST_READ_LOW,
                    read_slot_ticks:         RST_READ_SLOT};
         phase = PH_IDLE;
         slot_ticks = '0;
         bit_num = '0;
         shifter = '0;
         presence_seen = 1'b0;
         line_pulled = 1'b0;
         last_read = '0;
         predicted_responses.delete();
         waiting = 0;
         mismatches = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_response(req_tuser, req_tdata[0], req_tdata[8:1], predicted);
            predicted_responses.push_back(predicted);
            waiting++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_responses.size() == 0) begin
               mismatches++;
               $display("%0t: response %h arrived with nothing expected, got %h",
                        $time, rsp_tdata, rsp_tdata);
            end else begin
               oldest = predicted_responses.pop_front();
               waiting--;
               check_field("drive_low", 8'(oldest.drive_low), 8'(rsp_tdata[0]));
               check_field("busy_res", 8'(oldest.busy_res), 8'(rsp_tdata[1]));
               check_field("done_res", 8'(oldest.done_res), 8'(rsp_tdata[2]));
               check_field("presence", 8'(oldest.presence), 8'(rsp_tdata[3]));
               check_field("read_data", oldest.read_data, rsp_tdata[11:4]);
               check_field("rejected", 8'(oldest.rejected), 8'(rsp_tdata[12]));
               check_field("zero fill", 8'h00, 8'(rsp_tdata[15:13]));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_RESET_LOW:     timing.reset_low_ticks = csr_wdata;
               REG_PRESENCE_WAIT: timing.presence_wait_ticks = csr_wdata;
               REG_PRESENCE_REC:  timing.presence_recovery_ticks = csr_wdata;
               REG_WRITE_ONE_LOW: timing.write_one_low_ticks = csr_wdata;
               REG_WRITE_SLOT:    timing.write_slot_ticks = csr_wdata;
               REG_READ_LOW:      timing.read_low_ticks = csr_wdata;
               REG_READ_SLOT:     timing.read_slot_ticks = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- tb/one_wire_bus_master_top_tb.sv -----
// Testbench top for the 1-Wire bus master: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module one_wire_bus_master_top_tb;
   import owbm_pkg::*;

   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned QUIET_LIMIT     = 20000;
   localparam int unsigned RANDOM_SETS     = 8;
   localparam int unsigned ITEMS_PER_SET   = 150;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER [7] = '{REG_RESET_LOW, REG_PRESENCE_WAIT,
      REG_PRESENCE_REC, REG_WRITE_ONE_LOW, REG_WRITE_SLOT, REG_READ_LOW, REG_READ_SLOT};
   localparam logic [1:0] CMD_KINDS [3] = '{ACT_RESET, ACT_WRITE, ACT_READ};

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // line_level, data_byte, zero fill
   logic [1:0]            req_tuser;   // action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;   // drive_low, busy_res, done_res, presence,
                                       // read_data, rejected, zero fill
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [TICK_W-1:0]     csr_wdata;

   int unsigned           fault_count;
   int unsigned           tx_idle_pct;
   int unsigned           rx_stall_pct;
   int unsigned           tick_level_mode;  // 0 low, 1 high, 2 random
   bit                    hold_req;
   int unsigned           sent_n;
   int unsigned           recv_n;
   int unsigned           quiet_cycles;
   logic                  last_busy;

   one_wire_bus_master_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   one_wire_bus_master_checker response_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fault_count (fault_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: random stalls, or one long hold-off when asked for.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   // Transfer counts, the busy flag of the newest response, and the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         sent_n <= 0;
         recv_n <= 0;
         last_busy <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) sent_n <= sent_n + 1;
         if (rsp_tvalid && rsp_tready) begin
            recv_n <= recv_n + 1;
            last_busy <= rsp_tdata[1];
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("one_wire_bus_master_top regression: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offers one request and returns at the edge where it is transferred.
   task automatic send_item(input logic [1:0] kind, input logic level,
                            input logic [7:0] data_val);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, data_val, level};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_tick();
      logic level;
      level = (tick_level_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(tick_level_mode);
      send_item(ACT_TICK, level, 8'($urandom_range(0, 255)));
   endtask

   // Stops offering until every transfer so far has its response, then lets
   // the input and result registers empty.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sent_n != recv_n);
      repeat (3) @(posedge clock);
   endtask

   // Ticks until the running operation is over and all responses are in.
   task automatic settle();
      do begin
         while (last_busy) send_tick();
         wait_drain();
      end while (last_busy);
   endtask

   task automatic run_op(input logic [1:0] kind, input logic [7:0] data_val,
                         input int unsigned level_mode);
      send_item(kind, 1'($urandom_range(0, 1)), data_val);
      tick_level_mode = level_mode;
      settle();
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Writes every timing register with a value drawn from lo..hi.
   task automatic program_range(input int unsigned lo, input int unsigned hi);
      for (int i = 0; i < 7; i++) write_reg(REG_ORDER[i], TICK_W'($urandom_range(lo, hi)));
      csr_we <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ACT_TICK;
      csr_we <= 1'b0;
      csr_addr <= REG_RESET_LOW;
      csr_wdata <= '0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      tick_level_mode = 2;
      hold_req = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero-length registers: every interval shrinks to a single tick.
      program_range(0, 0);
      send_item(ACT_TICK, 1'b0, 8'h00);
      send_item(ACT_TICK, 1'b1, 8'hFF);
      // Commands that arrive during a reset are refused.
      send_item(ACT_RESET, 1'b0, 8'h00);
      send_item(ACT_WRITE, 1'b1, 8'hFF);
      send_item(ACT_READ, 1'b0, 8'h00);
      send_item(ACT_RESET, 1'b1, 8'h55);
      tick_level_mode = 0;
      settle();
      // A reset with no presence pulse, then writes and reads of every shape.
      run_op(ACT_RESET, 8'h00, 1);
      run_op(ACT_WRITE, 8'h00, 2);
      run_op(ACT_WRITE, 8'hFF, 2);
      run_op(ACT_WRITE, 8'hA5, 2);
      run_op(ACT_READ, 8'hFF, 1);
      run_op(ACT_READ, 8'h00, 0);
      run_op(ACT_READ, 8'h5A, 2);

      // Moderate intervals of several ticks each.
      program_range(8, 16);
      run_op(ACT_RESET, 8'h00, 0);
      run_op(ACT_WRITE, 8'h3C, 2);
      run_op(ACT_READ, 8'h00, 2);

      // Random traffic over short random timings, one idling pattern per set.
      for (int s = 0; s < RANDOM_SETS; s++) begin
         program_range(0, (s % 2) ? 2 : 6);
         case (s % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
            default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
         endcase
         // The first set opens with a long response hold-off to back up the input.
         if (s == 0) hold_req = 1'b1;
         tick_level_mode = 2;
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            if ($urandom_range(0, 99) < 6) begin
               send_item(CMD_KINDS[$urandom_range(0, 2)], 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            end else begin
               send_tick();
            end
         end
         settle();
      end

      wait_drain();
      if (fault_count == 0) begin
         $display("one_wire_bus_master_top regression: pass");
      end else begin
         $display("one_wire_bus_master_top regression: fail");
      end
      $finish;
   end

endmodule
